[src/stp_pkg.sv]
package stp_pkg;

  // Field and accumulator widths fixed by the value range
  localparam int TOTAL_W      = 39;
  localparam int VALUE_W      = 40;
  localparam int INT_W        = 7;
  localparam int MFRAC_W      = 20;
  localparam int TAIL_W       = 10;
  localparam int UNITS_W      = 12;
  localparam int WEIGHT_W     = 32;
  localparam int MFRAC_DIGITS = 6;

  // Characters the scanner reacts to
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Hours must stay below this in right ascension
  localparam logic [INT_W-1:0] RA_HOUR_LIMIT = 7'd24;

  typedef logic [1:0] part_t;
  localparam part_t PART_HOURS   = 2'd0;
  localparam part_t PART_MINUTES = 2'd1;
  localparam part_t PART_SECONDS = 2'd2;

  // Scan result handed from the character scanner to the value pipeline
  typedef struct packed {
    logic               ok;
    logic               neg;
    part_t              part;
    logic [TOTAL_W-1:0] total;
    logic [INT_W-1:0]   int_v;
    logic [MFRAC_W-1:0] mfrac;
    logic [TAIL_W-1:0]  tail;
  } fin_rec_t;

  // Power of ten, for elaboration-time constants only
  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Weight of one unit of a part, in millionths of a second
  function automatic logic [WEIGHT_W-1:0] part_weight(input part_t part);
    case (part)
      PART_HOURS:   part_weight = 32'd3600000000;
      PART_MINUTES: part_weight = 32'd60000000;
      PART_SECONDS: part_weight = 32'd1000000;
      default:      part_weight = 32'd0;
    endcase
  endfunction

  // Seconds in one unit of a part
  function automatic logic [UNITS_W-1:0] part_units(input part_t part);
    case (part)
      PART_HOURS:   part_units = 12'd3600;
      PART_MINUTES: part_units = 12'd60;
      PART_SECONDS: part_units = 12'd1;
      default:      part_units = 12'd0;
    endcase
  endfunction

endpackage

[src/sexagesimal_text_parser.sv]
// Sexagesimal angle text parser.
// Input stream: one ASCII character per transfer in in_tdata, in_tlast set
// on the final character of a string. One result per string is offered on
// the output stream: out_tuser is the accept flag, out_tdata the signed
// angle in millionths of a second (of time or arc), zero when rejected.
// cfg_data selects declination (1) or right ascension (0); write it only
// while no string is in flight. cfg_ready is always high.
// Throughput: one character per cycle, strings back to back, while in_tready
// stays high. The record register takes the scan result at the transfer of
// the last character; the product stage, the partial-sum stage and the
// output register follow it in that order, and the output register offers
// the result.
// When the receiver stalls, finished results queue in the pipeline
// stages; in_tready drops only once every stage holds a result.
// Reset (rst_n low, synchronous) empties the pipeline, clears the scan
// state and selects right ascension.
module sexagesimal_text_parser #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [39:0] angle_value
  output logic        out_tuser,  // [0] parse_ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import stp_pkg::*;

  logic     mode_r;
  logic     accept;
  logic     rec_valid;
  logic     fin_ready;
  fin_rec_t rec;

  // Mode register, written on a configuration transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // Take a character unless a record still waits for the pipeline
  assign in_tready = !rec_valid || fin_ready;
  assign accept    = in_tvalid && in_tready;

  stp_scan #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .accept    (accept),
    .text_char (in_tdata),
    .last_char (in_tlast),
    .fin_ready (fin_ready),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  stp_finish #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec       (rec),
    .fin_ready (fin_ready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_ok    (out_tuser),
    .out_value (out_tdata)
  );

endmodule

[src/stp_scan.sv]
module stp_scan #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             mode,
  input  logic             accept,
  input  logic [7:0]       text_char,
  input  logic             last_char,
  input  logic             fin_ready,
  output logic             rec_valid,
  output stp_pkg::fin_rec_t rec
);
  import stp_pkg::*;

  localparam int FC_W        = $clog2(FRAC_DIGITS + 1);
  localparam int M_DIGITS    = (FRAC_DIGITS < MFRAC_DIGITS) ? FRAC_DIGITS : MFRAC_DIGITS;
  localparam int TAIL_DIGITS = FRAC_DIGITS - M_DIGITS;
  localparam logic [TAIL_W-1:0] TAIL_P0 = TAIL_W'(pow10(TAIL_DIGITS - 1));
  localparam logic [TAIL_W-1:0] TAIL_P1 = TAIL_W'(pow10(TAIL_DIGITS - 2));
  localparam logic [TAIL_W-1:0] TAIL_P2 = TAIL_W'(pow10(TAIL_DIGITS - 3));

  // Place value of a fraction digit, microsecond resolution
  function automatic logic [MFRAC_W-1:0] m_pos(input logic [3:0] j);
    case (j)
      4'd0:    m_pos = 20'd100000;
      4'd1:    m_pos = 20'd10000;
      4'd2:    m_pos = 20'd1000;
      4'd3:    m_pos = 20'd100;
      4'd4:    m_pos = 20'd10;
      4'd5:    m_pos = 20'd1;
      default: m_pos = 20'd0;
    endcase
  endfunction

  part_t              part_r, part_nxt;
  logic [1:0]         icnt_r, icnt_nxt;
  logic [INT_W-1:0]   int_r, int_nxt;
  logic               dot_r, dot_nxt;
  logic [FC_W-1:0]    fcnt_r, fcnt_nxt;
  logic [MFRAC_W-1:0] mfrac_r, mfrac_nxt;
  logic [TAIL_W-1:0]  tail_r, tail_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               fail_r, fail_nxt;
  logic               stop_r, stop_nxt;
  logic               neg_r, neg_nxt;
  logic               first_r, first_nxt;
  logic               rec_valid_r, rec_valid_nxt;
  fin_rec_t           rec_r, rec_nxt;

  logic               is_digit;
  logic               is_sep;
  logic [3:0]         digit;
  logic [TOTAL_W-1:0] close_sum;
  logic               close_bad;
  logic               split;
  logic               to_frac;
  logic [INT_W-1:0]   int_base;
  logic [1:0]         icnt_base;
  logic [TAIL_W-1:0]  tail_pos;
  logic               pending;
  logic               keep;

  // Classify the character; digits carry their value in the low nibble
  assign is_digit = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
  assign is_sep   = (text_char == CH_COLON) || (text_char == CH_SPACE);
  assign digit    = text_char[3:0];

  // Closing the current part adds its integer times the part weight
  assign close_sum = total_r + TOTAL_W'(int_r) * TOTAL_W'(part_weight(part_r));
  assign close_bad = !mode && (part_r == PART_HOURS) && (int_r >= RA_HOUR_LIMIT);

  // A third integer digit opens the next part, or the fraction in seconds
  assign split     = (icnt_r == 2'd2) && !dot_r && (part_r < PART_SECONDS);
  assign to_frac   = dot_r || ((icnt_r == 2'd2) && !split);
  assign int_base  = split ? '0 : int_r;
  assign icnt_base = split ? 2'd0 : icnt_r;

  assign tail_pos = (fcnt_r == FC_W'(M_DIGITS))     ? TAIL_P0 :
                    (fcnt_r == FC_W'(M_DIGITS + 1)) ? TAIL_P1 : TAIL_P2;

  // Advance the scan state by one character
  always_comb begin
    part_nxt  = part_r;
    icnt_nxt  = icnt_r;
    int_nxt   = int_r;
    dot_nxt   = dot_r;
    fcnt_nxt  = fcnt_r;
    mfrac_nxt = mfrac_r;
    tail_nxt  = tail_r;
    total_nxt = total_r;
    fail_nxt  = fail_r;
    stop_nxt  = stop_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    if (accept) begin
      first_nxt = 1'b0;
      if (!fail_r && !stop_r) begin
        if (mode && first_r && ((text_char == CH_PLUS) || (text_char == CH_MINUS))) begin
          neg_nxt = (text_char == CH_MINUS);
        end else if (is_digit) begin
          if (split && close_bad) begin
            fail_nxt = 1'b1;
          end else begin
            if (split) begin
              total_nxt = close_sum;
              part_nxt  = part_r + 2'd1;
            end
            if (to_frac) begin
              dot_nxt = 1'b1;
              if (fcnt_r < FC_W'(FRAC_DIGITS)) begin
                if (fcnt_r < FC_W'(M_DIGITS)) begin
                  mfrac_nxt = mfrac_r + MFRAC_W'(digit) * m_pos(4'(fcnt_r));
                end else begin
                  tail_nxt = tail_r + TAIL_W'(digit) * tail_pos;
                end
                fcnt_nxt = fcnt_r + FC_W'(1);
              end
            end else begin
              int_nxt  = INT_W'(int_base * 7'd10 + INT_W'(digit));
              icnt_nxt = icnt_base + 2'd1;
            end
          end
        end else if (is_sep) begin
          if (dot_r || (part_r >= PART_SECONDS)) begin
            fail_nxt = 1'b1;
          end else if ((icnt_r != 2'd0) && close_bad) begin
            fail_nxt = 1'b1;
          end else begin
            if (icnt_r != 2'd0) begin
              total_nxt = close_sum;
              icnt_nxt  = 2'd0;
              int_nxt   = '0;
            end
            part_nxt = part_r + 2'd1;
          end
        end else if ((text_char == CH_DOT) && !dot_r) begin
          dot_nxt = 1'b1;
        end else if (mode) begin
          fail_nxt = 1'b1;
        end else begin
          stop_nxt = 1'b1;
        end
      end
    end
  end

  // Build the result record from the state after the last character
  assign pending = (icnt_nxt != 2'd0) || (fcnt_nxt != '0);
  assign keep    = !fail_nxt && pending &&
                   !(!mode && (part_nxt == PART_HOURS) && (int_nxt >= RA_HOUR_LIMIT));

  always_comb begin
    rec_nxt.ok    = !fail_nxt;
    rec_nxt.neg   = neg_nxt && !fail_nxt;
    rec_nxt.part  = part_nxt;
    rec_nxt.total = fail_nxt ? '0 : total_nxt;
    rec_nxt.int_v = keep ? int_nxt : '0;
    rec_nxt.mfrac = keep ? mfrac_nxt : '0;
    rec_nxt.tail  = keep ? tail_nxt : '0;
  end

  // Hold the record until the value pipeline takes it
  always_comb begin
    rec_valid_nxt = rec_valid_r;
    if (accept && last_char) begin
      rec_valid_nxt = 1'b1;
    end else if (fin_ready) begin
      rec_valid_nxt = 1'b0;
    end
  end

  // Scan state: clear on reset and after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_char)) begin
      part_r  <= PART_HOURS;
      icnt_r  <= 2'd0;
      int_r   <= '0;
      dot_r   <= 1'b0;
      fcnt_r  <= '0;
      mfrac_r <= '0;
      tail_r  <= '0;
      total_r <= '0;
      fail_r  <= 1'b0;
      stop_r  <= 1'b0;
      neg_r   <= 1'b0;
      first_r <= 1'b1;
    end else begin
      part_r  <= part_nxt;
      icnt_r  <= icnt_nxt;
      int_r   <= int_nxt;
      dot_r   <= dot_nxt;
      fcnt_r  <= fcnt_nxt;
      mfrac_r <= mfrac_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
      fail_r  <= fail_nxt;
      stop_r  <= stop_nxt;
      neg_r   <= neg_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

endmodule

[src/stp_finish.sv]
module stp_finish #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rec_valid,
  input  stp_pkg::fin_rec_t          rec,
  output logic                       fin_ready,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [stp_pkg::VALUE_W-1:0] out_value
);
  import stp_pkg::*;

  localparam int PM_W = WEIGHT_W;
  localparam int PT_W = 22;
  localparam int TAIL_DIGITS = (FRAC_DIGITS > MFRAC_DIGITS) ? FRAC_DIGITS - MFRAC_DIGITS : 0;

  logic               b_ready, c_ready;
  logic               b_valid_r, c_valid_r, out_valid_r;
  logic               b_ok_r, b_neg_r, c_ok_r, c_neg_r, out_ok_r;
  logic [TOTAL_W-1:0] b_total_r, b_pint_r;
  logic [PM_W-1:0]    b_pm_r;
  logic [PT_W-1:0]    b_pt_r;
  logic [PT_W-1:0]    quot;
  logic [TOTAL_W-1:0] c_sum_r;
  logic [PT_W-1:0]    c_q_r;
  logic [TOTAL_W-1:0] out_sum;
  logic [VALUE_W-1:0] out_value_r;

  // Each stage moves when it is empty or its successor moves
  assign c_ready   = !out_valid_r || out_ready;
  assign b_ready   = !c_valid_r || c_ready;
  assign fin_ready = !b_valid_r || b_ready;

  // Tail quotient: floor by the sub-microsecond scale, by reciprocal
  if (TAIL_DIGITS == 0) begin : g_no_tail
    assign quot = b_pt_r;
  end else begin : g_tail
    localparam int          RECIP_SHIFT = 34;
    localparam longint      TAIL_DIV    = pow10(TAIL_DIGITS);
    localparam logic [31:0] RECIP       =
      32'(((64'd1 << RECIP_SHIFT) + TAIL_DIV - 1) / TAIL_DIV);
    logic [55:0] prod;
    assign prod = 56'(b_pt_r) * 56'(RECIP);
    assign quot = prod[RECIP_SHIFT +: PT_W];
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_ready) begin
        b_valid_r <= rec_valid;
      end
      if (b_ready) begin
        c_valid_r <= b_valid_r;
      end
      if (c_ready) begin
        out_valid_r <= c_valid_r;
      end
    end
  end

  // Products of each term with its part scale
  always_ff @(posedge clk) begin
    if (fin_ready) begin
      b_ok_r    <= rec.ok;
      b_neg_r   <= rec.neg;
      b_total_r <= rec.total;
      b_pint_r  <= TOTAL_W'(rec.int_v) * TOTAL_W'(part_weight(rec.part));
      b_pm_r    <= PM_W'(rec.mfrac) * PM_W'(part_units(rec.part));
      b_pt_r    <= PT_W'(rec.tail) * PT_W'(part_units(rec.part));
    end
  end

  // Partial sum and tail quotient
  always_ff @(posedge clk) begin
    if (b_ready) begin
      c_ok_r  <= b_ok_r;
      c_neg_r <= b_neg_r;
      c_sum_r <= b_total_r + b_pint_r + TOTAL_W'(b_pm_r);
      c_q_r   <= quot;
    end
  end

  // Final sum, sign applied
  assign out_sum = c_sum_r + TOTAL_W'(c_q_r);

  always_ff @(posedge clk) begin
    if (c_ready) begin
      out_ok_r    <= c_ok_r;
      out_value_r <= c_neg_r ? (VALUE_W'(0) - {1'b0, out_sum}) : {1'b0, out_sum};
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_value = out_value_r;

endmodule

[src/stp_checker.sv]
module stp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Drop the value of a rejected string to zero
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("rejected result carries a value");

  // Input backs up only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Configuration transfers are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

endmodule

bind sexagesimal_text_parser stp_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import stp_pkg::*;

  localparam int FRAC_DIGITS = 6;
  localparam longint unsigned FRAC_SCALE = 64'd10 ** FRAC_DIGITS;

  typedef struct {
    bit        ok;
    bit [39:0] value;
  } angle_result_t;

  // Scoreboard: scans characters the way the parser does and queues angles
  class angle_scoreboard;
    bit                dec_mode;
    part_t             part;
    int unsigned       int_cnt;
    int unsigned       int_acc;
    bit                dot;
    int unsigned       frac_cnt;
    longint unsigned   frac_acc;
    bit [TOTAL_W-1:0]  total;
    bit                failed;
    bit                stopped;
    bit                neg;
    bit                first;
    angle_result_t     due_q[$];
    int unsigned       errors;

    function new();
      dec_mode = 1'b0;
      errors   = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      part     = PART_HOURS;
      int_cnt  = 0;
      int_acc  = 0;
      dot      = 1'b0;
      frac_cnt = 0;
      frac_acc = 0;
      total    = '0;
      failed   = 1'b0;
      stopped  = 1'b0;
      neg      = 1'b0;
      first    = 1'b1;
    endfunction

    function longint unsigned unit_weight(part_t p);
      case (p)
        PART_HOURS:   return 64'd3600000000;
        PART_MINUTES: return 64'd60000000;
        PART_SECONDS: return 64'd1000000;
        default:      return 64'd0;
      endcase
    endfunction

    // Add a closed part; refuse an hour of 24 or more in right ascension
    function bit close_part(int unsigned v);
      if (!dec_mode && part == PART_HOURS && v >= 24) return 1'b0;
      total = total + TOTAL_W'(64'(v) * unit_weight(part));
      return 1'b1;
    endfunction

    function void bad_char();
      if (dec_mode) failed = 1'b1;
      else stopped = 1'b1;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Advance the scan by one accepted character
    function void note_char(bit [7:0] c, bit last);
      int unsigned     d;
      bit              split_ok;
      longint unsigned sum;
      longint unsigned w;
      longint unsigned f;
      bit [39:0]       v40;
      angle_result_t   r;
      if (!failed && !stopped) begin
        if (dec_mode && first && (c == CH_PLUS || c == CH_MINUS)) begin
          neg = (c == CH_MINUS);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          d = c - CH_ZERO;
          split_ok = 1'b1;
          // third integer digit closes the part or opens the fraction
          if (int_cnt == 2 && !dot) begin
            if (part < PART_SECONDS) begin
              if (!close_part(int_acc)) begin
                failed = 1'b1;
                split_ok = 1'b0;
              end else begin
                part = part + 2'd1;
                int_cnt = 0;
                int_acc = 0;
              end
            end else begin
              dot = 1'b1;
            end
          end
          if (split_ok) begin
            if (dot) begin
              if (frac_cnt < FRAC_DIGITS) begin
                frac_acc = frac_acc * 10 + d;
                frac_cnt++;
              end
            end else begin
              int_acc = int_acc * 10 + d;
              int_cnt++;
            end
          end
        end else if (c == CH_COLON || c == CH_SPACE) begin
          if (dot || part >= PART_SECONDS) begin
            failed = 1'b1;
          end else if (int_cnt != 0 && !close_part(int_acc)) begin
            failed = 1'b1;
          end else begin
            int_cnt = 0;
            int_acc = 0;
            part = part + 2'd1;
          end
        end else if (c == CH_DOT) begin
          if (dot) bad_char();
          else dot = 1'b1;
        end else begin
          bad_char();
        end
      end
      first = 1'b0;
      if (!last) return;

      // Close out the string: pending digits, truncated fraction, sign
      if (failed) begin
        r.ok = 1'b0;
        r.value = '0;
      end else begin
        sum = 64'(total);
        if ((int_cnt != 0 || frac_cnt != 0) &&
            !(!dec_mode && part == PART_HOURS && int_acc >= 24)) begin
          w = unit_weight(part);
          f = frac_acc;
          for (int i = frac_cnt; i < FRAC_DIGITS; i++) f = f * 10;
          sum = sum + 64'(int_acc) * w + (f * w) / FRAC_SCALE;
        end
        v40 = {1'b0, sum[TOTAL_W-1:0]};
        if (neg) v40 = -v40;
        r.ok = 1'b1;
        r.value = v40;
      end
      due_q.push_back(r);
      clear_scan();
    endfunction

    // Compare one delivered result with the oldest queued one
    function void check_result(bit ok, bit [39:0] value);
      angle_result_t r;
      if (due_q.size() == 0) begin
        $error("unexpected result: parse_ok %0b angle_value %0d", ok, $signed(value));
        errors++;
        return;
      end
      r = due_q.pop_front();
      if (ok !== r.ok) begin
        $error("parse_ok: expected %0b, actual %0b", r.ok, ok);
        errors++;
      end
      if (value !== r.value) begin
        $error("angle_value: expected %0d, actual %0d", $signed(r.value), $signed(value));
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] text_char
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [39:0] angle_value
  logic        out_tuser;  // [0] parse_ok
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  angle_scoreboard angle_sb = new();
  bit              idle_on = 1'b1;
  bit [7:0]        text_q[$];

  sexagesimal_text_parser #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case a handshake never completes
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) angle_sb.check_result(out_tuser, out_tdata);
  end

  // Stall the result side in random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Transfer one character, with an optional gap ahead of it
  task automatic drive_char(bit [7:0] c, bit last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    angle_sb.note_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) drive_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_str(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Drain, let the pipeline settle, then write the mode register
  task automatic write_mode(bit m);
    in_tvalid <= 1'b0;
    while (angle_sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    angle_sb.dec_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_digits(int unsigned v, int unsigned ndig);
    if (ndig == 2) text_q.push_back(CH_ZERO + 8'((v / 10) % 10));
    if (ndig >= 1) text_q.push_back(CH_ZERO + 8'(v % 10));
  endfunction

  // Build a mostly well-formed angle, sometimes corrupted, sometimes noise
  function automatic void build_text(bit dec);
    int unsigned nparts;
    int unsigned ndig;
    int unsigned v;
    int unsigned pos;
    text_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(0, 255)));
        else text_q.push_back(8'($urandom_range(CH_SPACE, CH_NINE)));
      end
      return;
    end
    if (dec) begin
      case ($urandom_range(0, 3))
        0: text_q.push_back(CH_MINUS);
        1: text_q.push_back(CH_PLUS);
        default: ;
      endcase
    end
    nparts = $urandom_range(1, 3);
    for (int p = 0; p < nparts; p++) begin
      if (p > 0 && $urandom_range(0, 5) != 0)
        text_q.push_back($urandom_range(0, 1) ? CH_COLON : CH_SPACE);
      ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 2;
      if (p == 0 && !dec) v = $urandom_range(0, 26);
      else if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 99);
      else v = $urandom_range(0, 59);
      push_digits(v, ndig);
    end
    if ($urandom_range(0, 1)) begin
      text_q.push_back(CH_DOT);
      repeat ($urandom_range(0, 9)) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (text_q.size() == 0) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    // corrupt one position now and then
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 2))
        0: text_q[pos] = 8'($urandom_range(0, 255));
        1: text_q.insert(pos, CH_DOT);
        default: text_q.insert(pos, $urandom_range(0, 1) ? CH_MINUS : CH_COLON);
      endcase
    end
  endfunction

  initial begin
    string ra_cases[] = '{"5", "23:59:59.1234567", "24:00", "25", "123", "1.2.3",
                          "1x5", "-5", "1:2:3:", "1.5:", "::", "235959",
                          "00:00:5912"};
    string dec_cases[] = '{"-90:30:00.5", "+1", "-0", "1.2.3", "1-", "-",
                           "99 59 59.999999", " 5"};
    int unsigned phase_chars;
    bit          m;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: right ascension corner cases, NUL and all-ones characters
    write_mode(1'b0);
    foreach (ra_cases[i]) send_str(ra_cases[i]);
    text_q = '{8'h00};
    send_text();
    text_q = '{8'h31, 8'hFF, 8'h32};
    send_text();

    // Directed: declination corner cases
    write_mode(1'b1);
    foreach (dec_cases[i]) send_str(dec_cases[i]);
    text_q = '{8'hFF};
    send_text();

    // Random phases; the last one runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      m = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      write_mode(m);
      if (ph == 5) idle_on = 1'b0;
      phase_chars = 0;
      while (phase_chars < 55) begin
        build_text(m);
        phase_chars += text_q.size();
        send_text();
      end
    end

    in_tvalid <= 1'b0;
    while (angle_sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (angle_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/stp_pkg.sv
src/stp_scan.sv
src/stp_finish.sv
src/sexagesimal_text_parser.sv
src/stp_checker.sv
dv/tb_top.sv
